/* hw/rtl/nasp_pkg.sv */
// ----------------------------------------------------------------------------
// nasp_pkg
// Shared types, codes and character helpers of the address string parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nasp_pkg;

  localparam int unsigned DomainCharsDefault = 8;
  localparam int unsigned DomainW = 64;
  localparam int unsigned PartW   = 16;
  localparam int unsigned MaskW   = 5;
  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_REQUIRED_MASK  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_DEFAULT_ZONE   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DEFAULT_NET    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DEFAULT_NODE   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DEFAULT_POINT  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DEFAULT_DOMAIN = 3'd5;

  // Scanner phase codes
  localparam logic [2:0] PH_SKIP      = 3'd0;
  localparam logic [2:0] PH_NUM_START = 3'd1;
  localparam logic [2:0] PH_MINUS     = 3'd2;
  localparam logic [2:0] PH_DIGITS    = 3'd3;
  localparam logic [2:0] PH_NEG       = 3'd4;
  localparam logic [2:0] PH_DOMAIN    = 3'd5;
  localparam logic [2:0] PH_OK        = 3'd6;
  localparam logic [2:0] PH_FAIL      = 3'd7;

  // Part numbers; LEAD_PART marks a leading number of unknown role
  localparam logic [2:0] PART_ZONE  = 3'd0;
  localparam logic [2:0] PART_NET   = 3'd1;
  localparam logic [2:0] PART_NODE  = 3'd2;
  localparam logic [2:0] PART_POINT = 3'd3;
  localparam logic [2:0] LEAD_PART  = 3'd4;

  localparam int unsigned DomainBit = 4;

  // Character classes
  localparam logic [3:0] KEY_COLON = 4'd1;
  localparam logic [3:0] KEY_SLASH = 4'd2;
  localparam logic [3:0] KEY_DOT   = 4'd3;
  localparam logic [3:0] KEY_AT    = 4'd4;
  localparam logic [3:0] KEY_NUL   = 4'd5;
  localparam logic [3:0] KEY_SPACE = 4'd6;
  localparam logic [3:0] KEY_TAB   = 4'd7;
  localparam logic [3:0] KEY_CR    = 4'd8;
  localparam logic [3:0] KEY_LF    = 4'd9;
  localparam logic [3:0] KEY_OTHER = 4'd10;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam logic [18:0] NumMax = 19'd32767;

  typedef struct packed {
    logic [MaskW-1:0]           required_mask;
    logic [3:0][PartW-1:0]      def_part;     // zone, net, node, point
    logic [DomainW-1:0]         def_domain;
  } cfg_t;

  typedef struct packed {
    logic                       fail;
    logic [MaskW-1:0]           seen;
    logic [3:0][PartW-1:0]      parts;
    logic [DomainW-1:0]         domain;
    logic [PartW-1:0]           pos;
  } res_t;

  function automatic logic [3:0] key_of(input logic [7:0] c);
    logic [3:0] k;
    case (c)
      CH_COLON: k = KEY_COLON;
      CH_SLASH: k = KEY_SLASH;
      CH_DOT:   k = KEY_DOT;
      CH_AT:    k = KEY_AT;
      CH_NUL:   k = KEY_NUL;
      CH_SPACE: k = KEY_SPACE;
      CH_TAB:   k = KEY_TAB;
      CH_CR:    k = KEY_CR;
      CH_LF:    k = KEY_LF;
      default:  k = KEY_OTHER;
    endcase
    return k;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/network_address_string_parser.sv */
// ----------------------------------------------------------------------------
// network_address_string_parser
// Parses zone:net/node.point@domain strings, one character per word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one character per word,
//   ch_i, with last_i set on the final character of a string. A zero byte
//   stops the scan early; the string still ends at the word with last_i.
//   Output channel (out_valid_o / out_stall_i) carries one result word per
//   string: the four parts, the packed domain, found mask, error flag and
//   the offset of the character that stopped the scan, zero on error.
//   A string's result passes the input register, then the result register.
//   Throughput: one character per cycle while in_stall_o is low; the scanner
//   advances its state once per character in a single registered step.
//   While a result waits under out_stall_i, characters that end no string
//   keep flowing; a last character waits in the input register until the
//   result register frees, and meanwhile in_stall_o holds the input side.
//   Configuration writes (cfg_we_i, cfg_index_i, cfg_wdata_i) take effect on
//   the next edge; indexes past the default domain are dropped.
//   Reset clears the valid flags and the configuration registers, and puts
//   the scanner in the leading whitespace phase with no result pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module network_address_string_parser #(
  parameter int unsigned DOMAIN_CHARS = nasp_pkg::DomainCharsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    ch_i,
  input  wire logic                          last_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [15:0]                 zone_o,
  output logic signed [15:0]                 net_o,
  output logic signed [15:0]                 node_o,
  output logic signed [15:0]                 point_o,
  output logic [nasp_pkg::DomainW-1:0]       domain_o,
  output logic [nasp_pkg::MaskW-1:0]         found_mask_o,
  output logic                               error_o,
  output logic [15:0]                        stop_offset_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [nasp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [nasp_pkg::DomainW-1:0]  cfg_wdata_i
);

  nasp_pkg::cfg_t                    cfg;
  nasp_pkg::res_t                    res;
  logic                              res_valid;
  logic                              res_ready;
  logic [3:0][nasp_pkg::PartW-1:0]   parts;

  nasp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  nasp_scan #(
    .DOMAIN_CHARS (DOMAIN_CHARS)
  ) u_scan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .ch_i            (ch_i),
    .last_i          (last_i),
    .required_mask_i (cfg.required_mask),
    .res_ready_i     (res_ready),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  nasp_out_reg u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_valid_i   (res_valid),
    .res_i         (res),
    .cfg_i         (cfg),
    .res_ready_o   (res_ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .parts_o       (parts),
    .domain_o      (domain_o),
    .found_mask_o  (found_mask_o),
    .error_o       (error_o),
    .stop_offset_o (stop_offset_o)
  );

  assign zone_o  = parts[0];
  assign net_o   = parts[1];
  assign node_o  = parts[2];
  assign point_o = parts[3];

endmodule

`default_nettype wire

/* hw/rtl/nasp_cfg_regs.sv */
// ----------------------------------------------------------------------------
// nasp_cfg_regs
// Configuration registers: required parts mask and the default values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nasp_cfg_regs (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [nasp_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [nasp_pkg::DomainW-1:0]        cfg_wdata_i,
  output nasp_pkg::cfg_t                           cfg_o
);

  nasp_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        nasp_pkg::REG_REQUIRED_MASK:
          cfg_d.required_mask = cfg_wdata_i[nasp_pkg::MaskW-1:0];
        nasp_pkg::REG_DEFAULT_ZONE:   cfg_d.def_part[0] = cfg_wdata_i[15:0];
        nasp_pkg::REG_DEFAULT_NET:    cfg_d.def_part[1] = cfg_wdata_i[15:0];
        nasp_pkg::REG_DEFAULT_NODE:   cfg_d.def_part[2] = cfg_wdata_i[15:0];
        nasp_pkg::REG_DEFAULT_POINT:  cfg_d.def_part[3] = cfg_wdata_i[15:0];
        nasp_pkg::REG_DEFAULT_DOMAIN: cfg_d.def_domain  = cfg_wdata_i;
        default: ; // drop writes past the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* hw/rtl/nasp_scan.sv */
// ----------------------------------------------------------------------------
// nasp_scan
// Input word register and the per-character scanner state step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nasp_scan #(
  parameter int unsigned DOMAIN_CHARS = nasp_pkg::DomainCharsDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [7:0]            ch_i,
  input  wire logic                  last_i,
  input  wire logic [nasp_pkg::MaskW-1:0] required_mask_i,
  input  wire logic                  res_ready_i,
  output logic                       res_valid_o,
  output nasp_pkg::res_t             res_o
);

  localparam int unsigned DCW = $clog2(DOMAIN_CHARS + 1);
  localparam int unsigned DW  = 8 * DOMAIN_CHARS;

  typedef struct packed {
    logic [2:0]                        phase;
    logic [2:0]                        part;
    logic [14:0]                       acc;
    logic [3:0][nasp_pkg::PartW-1:0]   parts;
    logic [DW-1:0]                     domain;
    logic [nasp_pkg::MaskW-1:0]        seen;
    logic [nasp_pkg::PartW-1:0]        pos;
    logic [DCW-1:0]                    dcount;
  } scan_t;

  localparam scan_t ScanReset = '{phase: nasp_pkg::PH_SKIP,
                                  part:  nasp_pkg::LEAD_PART,
                                  default: '0};

  function automatic scan_t finish_ok(input scan_t s, input logic [4:0] req);
    scan_t n;
    n = s;
    n.phase = ((req & ~s.seen) != '0) ? nasp_pkg::PH_FAIL : nasp_pkg::PH_OK;
    return n;
  endfunction

  function automatic scan_t enter_domain(input scan_t s);
    scan_t n;
    n = s;
    n.dcount = '0;
    n.domain = '0;
    n.seen[nasp_pkg::DomainBit] = 1'b1;
    n.phase  = nasp_pkg::PH_DOMAIN;
    return n;
  endfunction

  function automatic scan_t after_part(input scan_t s, input logic [2:0] p,
                                       input logic [7:0] c, input logic [4:0] req);
    scan_t n;
    logic [3:0] k;
    logic [3:0] kp1;
    n = s;
    k = nasp_pkg::key_of(c);
    kp1 = {1'b0, p} + 4'd1;
    if (k == kp1 && k < nasp_pkg::KEY_AT) begin
      n.part  = k[2:0];
      n.acc   = '0;
      n.phase = nasp_pkg::PH_NUM_START;
    end else if (k > kp1 && k < nasp_pkg::KEY_AT) begin
      // separator skips a middle part
      n.phase = nasp_pkg::PH_FAIL;
    end else if (k == nasp_pkg::KEY_AT) begin
      n = enter_domain(s);
    end else begin
      n = finish_ok(s, req);
    end
    return n;
  endfunction

  function automatic scan_t num_end(input scan_t s, input logic neg,
                                    input logic [7:0] c, input logic [4:0] req);
    scan_t n;
    logic [3:0] k;
    logic [3:0] km1;
    logic [2:0] p;
    logic       bad;
    n = s;
    k = nasp_pkg::key_of(c);
    km1 = k - 4'd1;
    p = s.part;
    bad = 1'b0;
    if (s.part == nasp_pkg::LEAD_PART) begin
      // leading number takes its role from the following separator
      if (k inside {[nasp_pkg::KEY_COLON:nasp_pkg::KEY_DOT]}) begin
        p = km1[2:0];
      end else if (k inside {[nasp_pkg::KEY_AT:nasp_pkg::KEY_LF]}) begin
        p = nasp_pkg::PART_NODE;
      end else begin
        bad = 1'b1;
      end
    end
    if (!bad && p < nasp_pkg::PART_NODE && (neg || s.acc == '0)) begin
      bad = 1'b1;
    end
    if (bad) begin
      n.phase = nasp_pkg::PH_FAIL;
    end else begin
      n.parts[p[1:0]] = neg ? 16'hFFFF : {1'b0, s.acc};
      n.seen[p]       = 1'b1;
      n = after_part(n, p, c, req);
    end
    return n;
  endfunction

  function automatic scan_t num_start(input scan_t s, input logic [7:0] c,
                                      input logic [4:0] req);
    scan_t n;
    logic [3:0] k;
    n = s;
    k = nasp_pkg::key_of(c);
    if (c == nasp_pkg::CH_MINUS) begin
      n.phase = nasp_pkg::PH_MINUS;
    end else if (nasp_pkg::is_digit(c)) begin
      n.acc   = {11'd0, c[3:0]};
      n.phase = nasp_pkg::PH_DIGITS;
    end else if (s.part == nasp_pkg::LEAD_PART) begin
      if (k inside {[nasp_pkg::KEY_COLON:nasp_pkg::KEY_DOT]}) begin
        n.part  = k[2:0];
        n.acc   = '0;
        n.phase = nasp_pkg::PH_NUM_START;
      end else if (k == nasp_pkg::KEY_AT) begin
        n = enter_domain(s);
      end else begin
        n = finish_ok(s, req);
      end
    end else begin
      n.phase = nasp_pkg::PH_FAIL;
    end
    return n;
  endfunction

  function automatic scan_t feed(input scan_t s, input logic [7:0] c,
                                 input logic [4:0] req);
    scan_t       n;
    logic [18:0] acc;
    n = s;
    acc = 19'(s.acc) * 19'd10 + 19'(c[3:0]);
    case (s.phase)
      nasp_pkg::PH_SKIP: begin
        if (c != nasp_pkg::CH_SPACE && c != nasp_pkg::CH_TAB) begin
          n = num_start(s, c, req);
        end
      end
      nasp_pkg::PH_NUM_START: n = num_start(s, c, req);
      nasp_pkg::PH_MINUS: begin
        n.phase = (c == nasp_pkg::CH_ONE) ? nasp_pkg::PH_NEG : nasp_pkg::PH_FAIL;
      end
      nasp_pkg::PH_DIGITS: begin
        if (nasp_pkg::is_digit(c)) begin
          if (acc > nasp_pkg::NumMax) begin
            n.phase = nasp_pkg::PH_FAIL;
          end else begin
            n.acc = acc[14:0];
          end
        end else begin
          n = num_end(s, 1'b0, c, req);
        end
      end
      nasp_pkg::PH_NEG: n = num_end(s, 1'b1, c, req);
      nasp_pkg::PH_DOMAIN: begin
        if (s.dcount < DCW'(DOMAIN_CHARS) && nasp_pkg::is_alnum(c)) begin
          for (int i = 0; i < DOMAIN_CHARS; i++) begin
            if (s.dcount == DCW'(i)) begin
              n.domain[i*8 +: 8] = c;
            end
          end
          n.dcount = s.dcount + DCW'(1);
        end else begin
          n = finish_ok(s, req);
        end
      end
      default: ; // scan already stopped: ignore the word
    endcase
    if (n.phase != nasp_pkg::PH_OK && n.phase != nasp_pkg::PH_FAIL &&
        n.pos != 16'hFFFF) begin
      n.pos = n.pos + 16'd1;
    end
    return n;
  endfunction

  logic       s1_valid_q;
  logic [7:0] s1_ch_q;
  logic       s1_last_q;
  logic       fire;
  scan_t      state_q, state_d;
  scan_t      step1, step2;

  assign fire       = s1_valid_q && (!s1_last_q || res_ready_i);
  assign in_stall_o = s1_valid_q && !fire;

  always_comb begin
    step1 = feed(state_q, s1_ch_q, required_mask_i);
    // string ended without a zero byte: feed an implied one
    if (step1.phase != nasp_pkg::PH_OK && step1.phase != nasp_pkg::PH_FAIL) begin
      step2 = feed(step1, nasp_pkg::CH_NUL, required_mask_i);
    end else begin
      step2 = step1;
    end
  end

  always_comb begin
    state_d = state_q;
    if (fire) begin
      state_d = s1_last_q ? ScanReset : step1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      state_q    <= ScanReset;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_ch_q   <= ch_i;
      s1_last_q <= last_i;
    end
  end

  assign res_valid_o  = fire && s1_last_q;
  assign res_o.fail   = (step2.phase == nasp_pkg::PH_FAIL);
  assign res_o.seen   = step2.seen;
  assign res_o.parts  = step2.parts;
  assign res_o.domain = nasp_pkg::DomainW'(step2.domain);
  assign res_o.pos    = step2.pos;

endmodule

`default_nettype wire

/* hw/rtl/nasp_out_reg.sv */
// ----------------------------------------------------------------------------
// nasp_out_reg
// Result register: applies defaults and holds the result word until taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nasp_out_reg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         res_valid_i,
  input  wire nasp_pkg::res_t               res_i,
  input  wire nasp_pkg::cfg_t               cfg_i,
  output logic                              res_ready_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [3:0][nasp_pkg::PartW-1:0]   parts_o,
  output logic [nasp_pkg::DomainW-1:0]      domain_o,
  output logic [nasp_pkg::MaskW-1:0]        found_mask_o,
  output logic                              error_o,
  output logic [nasp_pkg::PartW-1:0]        stop_offset_o
);

  logic                              valid_q;
  logic [3:0][nasp_pkg::PartW-1:0]   parts_q, parts_d;
  logic [nasp_pkg::DomainW-1:0]      domain_q, domain_d;
  logic [nasp_pkg::MaskW-1:0]        found_q;
  logic                              error_q;
  logic [nasp_pkg::PartW-1:0]        offset_q, offset_d;

  assign res_ready_o = !valid_q || !out_stall_i;

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      parts_d[p] = (!res_i.fail && res_i.seen[p]) ? res_i.parts[p] : cfg_i.def_part[p];
    end
    domain_d = (!res_i.fail && res_i.seen[nasp_pkg::DomainBit]) ? res_i.domain
                                                               : cfg_i.def_domain;
    offset_d = res_i.fail ? '0 : res_i.pos;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_valid_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      parts_q  <= parts_d;
      domain_q <= domain_d;
      found_q  <= res_i.seen;
      error_q  <= res_i.fail;
      offset_q <= offset_d;
    end
  end

  assign out_valid_o   = valid_q;
  assign parts_o       = parts_q;
  assign domain_o      = domain_q;
  assign found_mask_o  = found_q;
  assign error_o       = error_q;
  assign stop_offset_o = offset_q;

endmodule

`default_nettype wire

/* hw/rtl/nasp_checker.sv */
// ----------------------------------------------------------------------------
// nasp_checker
// Port-level checks of the address string parser, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nasp_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic signed [15:0]            zone_o,
  input wire logic signed [15:0]            net_o,
  input wire logic signed [15:0]            node_o,
  input wire logic [nasp_pkg::DomainW-1:0]  domain_o,
  input wire logic [nasp_pkg::MaskW-1:0]    found_mask_o,
  input wire logic                          error_o,
  input wire logic [15:0]                   stop_offset_o
);

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(zone_o) && $stable(domain_o) && $stable(stop_offset_o))
    else $error("stalled result word changed");

  // Failed strings report offset zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> stop_offset_o == 16'd0)
    else $error("error result with nonzero stop offset");

  // A parsed zone and net lie in 1..32767.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !error_o && found_mask_o[0] |-> !zone_o[15] && zone_o != 16'sd0)
    else $error("parsed zone out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !error_o && found_mask_o[1] |-> !net_o[15] && net_o != 16'sd0)
    else $error("parsed net out of range");

  // A parsed node is -1 or nonnegative.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !error_o && found_mask_o[2] |-> !node_o[15] || node_o == -16'sd1)
    else $error("parsed node out of range");

endmodule

bind network_address_string_parser nasp_checker u_nasp_checker (.*);

`default_nettype wire
